// ----- hw/rtl/smp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

   // Top-level parse phase, one-hot
   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_START   = 6'b000010,
      PH_TYPE    = 6'b000100,
      PH_SIZE    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   // Exp-Golomb decoder phase, one-hot
   typedef enum logic [3:0] {
      GB_COUNT = 4'b0001,
      GB_READ  = 4'b0010,
      GB_DONE  = 4'b0100,
      GB_FAIL  = 4'b1000
   } golomb_phase_type;

   typedef struct packed {
      golomb_phase_type phase;
      logic [5:0]       zeros;
      logic [5:0]       bits_left;
      logic [31:0]      value;
   } golomb_state_type;

   // Input beat
   typedef struct packed {
      logic [7:0] nal_byte;
      logic       last_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [31:0] sei_type;
      logic [31:0] payload_size;
      logic        truncated;
      logic        has_recovery_count;
      logic [31:0] recovery_count;
      logic        has_uuid;
      logic [63:0] uuid_high;
      logic [63:0] uuid_low;
   } rsp_type;

   localparam logic [7:0]  EMU_BYTE         = 8'h03;
   localparam logic [7:0]  TRAILING_BYTE    = 8'h80;
   localparam logic [7:0]  RUN_BYTE         = 8'hFF;
   localparam logic [31:0] TYPE_UUID        = 32'd5;
   localparam logic [31:0] TYPE_RECOVERY    = 32'd6;
   localparam logic [4:0]  UUID_HIGH_BYTES  = 5'd8;
   localparam logic [4:0]  UUID_BYTES       = 5'd16;
   localparam logic [5:0]  GOLOMB_MAX_ZEROS = 6'd31;
   localparam logic [1:0]  HEADER_RESET     = 2'd1;

   localparam golomb_state_type GOLOMB_CLEAR = '{
      phase: GB_COUNT, zeros: 6'd0, bits_left: 6'd0, value: 32'd0
   };

endpackage

`default_nettype wire

// ----- hw/rtl/smp_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel with a typed payload
interface smp_chan_if #(
   parameter type data_type = logic [7:0]
) ();
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sei_message_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// SEI message parser. Feed the raw bytes of one SEI NAL unit on req_chan, one
// byte per beat, with last_byte on the final byte; the parser then restarts
// for the next unit. Emulation-prevention bytes are removed and the number of
// header bytes set through csr_chan (1 for AVC, 2 for HEVC; write only while
// idle) is skipped. One record per SEI message comes out on rsp_chan, with a
// truncated record if the unit ends inside a payload. The block takes one
// byte every clock unless a stalled rsp_chan holds back req_chan, which it
// does only once both the input register and the result register are full.
// A record passes the input register, which accepts its last byte, then the
// result register, from which it is offered on rsp_chan. The per-byte parse
// step between those registers, whose longest path is the eight-bit Exp-Golomb
// scan, sets the byte rate.
module sei_message_parser
   import smp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   smp_chan_if.sink    req_chan,
   smp_chan_if.source  rsp_chan,
   smp_chan_if.sink    csr_chan
);

   req_type in_ff, in_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    step;
   logic    rec_valid;
   rsp_type rec;

   // Pipeline moves when the result register is free or being drained
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   smp_parser_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .beat      (in_ff),
      .cfg_write (csr_chan.valid),
      .cfg_value (csr_chan.data),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   // Input register
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_in       = req_chan.data;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_in       = rec;
         rsp_valid_in = step && rec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // A held byte is neither dropped nor altered while the output stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost a byte under stall");

   // Truncated records carry no recovery count or uuid
   a_trunc_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.truncated |-> !rsp_ff.has_recovery_count && !rsp_ff.has_uuid)
      else $error("truncated record with decoded fields");

   // A uuid only comes from a type 5 payload of sixteen bytes or more
   a_uuid_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_uuid |->
         (rsp_ff.sei_type == TYPE_UUID) && (rsp_ff.payload_size >= 32'(UUID_BYTES)))
      else $error("uuid flagged on wrong payload");

   // A recovery count only comes from a complete type 6 payload
   a_rc_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.has_recovery_count |->
         (rsp_ff.sei_type == TYPE_RECOVERY) && (rsp_ff.payload_size != 32'd0))
      else $error("recovery count flagged on wrong payload");

endmodule

`default_nettype wire

// ----- hw/rtl/smp_golomb_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One byte of ue(v) decoding: eight bit steps, MSB first
module smp_golomb_step
   import smp_pkg::*;
(
   input  wire logic [7:0]       byte_in,
   input  wire golomb_state_type state_cur,
   output golomb_state_type      state_nxt
);

   always_comb begin
      golomb_state_type s;
      logic             bit_v;
      s = state_cur;
      for (int i = 0; i < 8; i++) begin
         bit_v = byte_in[3'(7 - i)];
         if (s.phase == GB_COUNT) begin
            if (bit_v) begin
               s.value = 32'd1;
               if (s.zeros == 6'd0) begin
                  s.phase = GB_DONE;
               end else begin
                  s.bits_left = s.zeros;
                  s.phase     = GB_READ;
               end
            end else begin
               s.zeros = s.zeros + 6'd1;
               if (s.zeros > GOLOMB_MAX_ZEROS) begin
                  s.phase = GB_FAIL;
               end
            end
         end else if (s.phase == GB_READ) begin
            s.value     = {s.value[30:0], bit_v};
            s.bits_left = s.bits_left - 6'd1;
            if (s.bits_left == 6'd0) begin
               s.phase = GB_DONE;
            end
         end
      end
      state_nxt = s;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/smp_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-byte SEI parse state and record formation
module smp_parser_core
   import smp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire req_type    beat,
   input  wire logic       cfg_write,
   input  wire logic [1:0] cfg_value,
   output logic            rec_valid,
   output rsp_type         rec
);

   logic [1:0]       header_bytes_ff, header_bytes_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       zero_run_ff, zero_run_in;
   logic [1:0]       header_left_ff, header_left_in;
   logic [31:0]      type_sum_ff, type_sum_in;
   logic [31:0]      size_sum_ff, size_sum_in;
   logic [31:0]      payload_left_ff, payload_left_in;
   logic [4:0]       payload_index_ff, payload_index_in;
   golomb_state_type golomb_ff, golomb_in, golomb_step_nxt;
   logic [63:0]      uuid_high_ff, uuid_high_in;
   logic [63:0]      uuid_low_ff, uuid_low_in;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic rsp_type make_record(
      input logic [31:0]      t,
      input logic [31:0]      sz,
      input logic             complete,
      input golomb_state_type g,
      input logic [63:0]      hi,
      input logic [63:0]      lo
   );
      rsp_type r;
      logic    has_rc;
      logic    has_id;
      has_rc                 = complete && (t == TYPE_RECOVERY) && (g.phase == GB_DONE);
      has_id                 = complete && (t == TYPE_UUID) && (sz >= 32'(UUID_BYTES));
      r.sei_type             = t;
      r.payload_size         = sz;
      r.truncated            = !complete;
      r.has_recovery_count   = has_rc;
      r.recovery_count       = has_rc ? (g.value - 32'd1) : 32'd0;
      r.has_uuid             = has_id;
      r.uuid_high            = has_id ? hi : 64'd0;
      r.uuid_low             = has_id ? lo : 64'd0;
      return r;
   endfunction

   smp_golomb_step u_golomb (
      .byte_in   (beat.nal_byte),
      .state_cur (golomb_ff),
      .state_nxt (golomb_step_nxt)
   );

   // Next-state logic for one byte
   always_comb begin
      logic [7:0] b;
      logic       data;
      b                = beat.nal_byte;
      data             = 1'b1;
      header_bytes_in  = header_bytes_ff;
      phase_in         = phase_ff;
      zero_run_in      = zero_run_ff;
      header_left_in   = header_left_ff;
      type_sum_in      = type_sum_ff;
      size_sum_in      = size_sum_ff;
      payload_left_in  = payload_left_ff;
      payload_index_in = payload_index_ff;
      golomb_in        = golomb_ff;
      uuid_high_in     = uuid_high_ff;
      uuid_low_in      = uuid_low_ff;
      rec_valid        = 1'b0;
      rec              = '0;

      // register write: reload header count while still in the header
      if (cfg_write) begin
         header_bytes_in = cfg_value;
         if (phase_ff == PH_HEADER) begin
            header_left_in = cfg_value;
         end
      end

      if (step) begin
         // emulation prevention
         if ((zero_run_ff >= 2'd2) && (b == EMU_BYTE)) begin
            data        = 1'b0;
            zero_run_in = 2'd0;
         end else if (b == 8'd0) begin
            if (zero_run_ff < 2'd2) begin
               zero_run_in = zero_run_ff + 2'd1;
            end
         end else begin
            zero_run_in = 2'd0;
         end

         // header skip
         if (data && (phase_in == PH_HEADER)) begin
            if (header_left_ff != 2'd0) begin
               header_left_in = header_left_ff - 2'd1;
               data           = 1'b0;
            end else begin
               phase_in = PH_START;
            end
         end

         if (data) begin
            // message start or trailing bits
            if (phase_in == PH_START) begin
               if (b == TRAILING_BYTE) begin
                  phase_in = PH_DONE;
               end else begin
                  type_sum_in = 32'd0;
                  size_sum_in = 32'd0;
                  phase_in    = PH_TYPE;
               end
            end

            if (phase_in == PH_TYPE) begin
               type_sum_in = sat_add(type_sum_in, {24'd0, b});
               if (b != RUN_BYTE) begin
                  phase_in = PH_SIZE;
               end
            end else if (phase_in == PH_SIZE) begin
               size_sum_in = sat_add(size_sum_in, {24'd0, b});
               if (b != RUN_BYTE) begin
                  payload_left_in  = size_sum_in;
                  payload_index_in = 5'd0;
                  golomb_in        = GOLOMB_CLEAR;
                  uuid_high_in     = 64'd0;
                  uuid_low_in      = 64'd0;
                  if (size_sum_in == 32'd0) begin
                     rec_valid = 1'b1;
                     rec       = make_record(type_sum_in, size_sum_in, 1'b1,
                                             GOLOMB_CLEAR, 64'd0, 64'd0);
                     phase_in  = PH_START;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end else if (phase_in == PH_PAYLOAD) begin
               // uuid capture over the first sixteen bytes
               if (payload_index_ff < UUID_HIGH_BYTES) begin
                  uuid_high_in = {uuid_high_ff[55:0], b};
               end else if (payload_index_ff < UUID_BYTES) begin
                  uuid_low_in = {uuid_low_ff[55:0], b};
               end
               if (payload_index_ff < UUID_BYTES) begin
                  payload_index_in = payload_index_ff + 5'd1;
               end
               if (type_sum_ff == TYPE_RECOVERY) begin
                  golomb_in = golomb_step_nxt;
               end
               payload_left_in = payload_left_ff - 32'd1;
               if (payload_left_in == 32'd0) begin
                  rec_valid = 1'b1;
                  rec       = make_record(type_sum_in, size_sum_in, 1'b1,
                                          golomb_in, uuid_high_in, uuid_low_in);
                  phase_in  = PH_START;
               end
            end
         end

         // end of unit: truncated record if inside a payload, then restart
         if (beat.last_byte) begin
            if ((phase_in == PH_PAYLOAD) && !rec_valid) begin
               rec_valid = 1'b1;
               rec       = make_record(type_sum_in, size_sum_in, 1'b0,
                                       GOLOMB_CLEAR, 64'd0, 64'd0);
            end
            phase_in         = PH_HEADER;
            zero_run_in      = 2'd0;
            header_left_in   = header_bytes_in;
            type_sum_in      = 32'd0;
            size_sum_in      = 32'd0;
            payload_left_in  = 32'd0;
            payload_index_in = 5'd0;
            golomb_in        = GOLOMB_CLEAR;
            uuid_high_in     = 64'd0;
            uuid_low_in      = 64'd0;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff  <= HEADER_RESET;
         phase_ff         <= PH_HEADER;
         zero_run_ff      <= 2'd0;
         header_left_ff   <= HEADER_RESET;
         type_sum_ff      <= 32'd0;
         size_sum_ff      <= 32'd0;
         payload_left_ff  <= 32'd0;
         payload_index_ff <= 5'd0;
         golomb_ff        <= GOLOMB_CLEAR;
         uuid_high_ff     <= 64'd0;
         uuid_low_ff      <= 64'd0;
      end else begin
         header_bytes_ff  <= header_bytes_in;
         phase_ff         <= phase_in;
         zero_run_ff      <= zero_run_in;
         header_left_ff   <= header_left_in;
         type_sum_ff      <= type_sum_in;
         size_sum_ff      <= size_sum_in;
         payload_left_ff  <= payload_left_in;
         payload_index_ff <= payload_index_in;
         golomb_ff        <= golomb_in;
         uuid_high_ff     <= uuid_high_in;
         uuid_low_ff      <= uuid_low_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/sei_record_checker.sv -----
`timescale 1ns / 1ps

// Watches the byte, record and header-count channels of the SEI parser,
// predicts each record from the accepted byte beats and compares field by field.
module sei_record_checker
   import smp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_ready,
   input  req_type     req_data,
   input  wire logic   rsp_valid,
   input  wire logic   rsp_ready,
   input  rsp_type     rsp_data,
   input  wire logic   csr_valid,
   input  wire logic   csr_ready,
   input  wire logic [1:0] csr_data,
   output int          fault_count,
   output int          records_pending
);

   // Parser state as predicted
   logic [1:0]       hdr_cfg;
   phase_type        phase;
   logic [1:0]       zero_run;
   logic [1:0]       hdr_left;
   logic [31:0]      type_acc;
   logic [31:0]      size_acc;
   logic [31:0]      bytes_left;
   logic [4:0]       byte_pos;
   golomb_phase_type eg_phase;
   logic [5:0]       eg_zeros;
   logic [5:0]       eg_bits;
   logic [31:0]      eg_val;
   logic [63:0]      id_hi;
   logic [63:0]      id_lo;

   rsp_type records_due[$];
   int      fault_tally = 0;

   initial begin
      fault_count     = 0;
      records_pending = 0;
   end

   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [7:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {25'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   task automatic clear_payload();
      byte_pos  = '0;
      eg_phase  = GB_COUNT;
      eg_zeros  = '0;
      eg_bits   = '0;
      eg_val    = '0;
      id_hi     = '0;
      id_lo     = '0;
   endtask

   // Fresh unit: header skip reloaded from the current register value
   task automatic start_unit();
      phase      = PH_HEADER;
      zero_run   = '0;
      hdr_left   = hdr_cfg;
      type_acc   = '0;
      size_acc   = '0;
      bytes_left = '0;
      clear_payload();
   endtask

   function automatic rsp_type make_record(input logic complete);
      rsp_type r;
      logic    rc;
      logic    id;
      rc = complete && type_acc == TYPE_RECOVERY && eg_phase == GB_DONE;
      id = complete && type_acc == TYPE_UUID && size_acc >= 32'd16;
      r.sei_type           = type_acc;
      r.payload_size       = size_acc;
      r.truncated          = !complete;
      r.has_recovery_count = rc;
      r.recovery_count     = rc ? eg_val - 32'd1 : '0;
      r.has_uuid           = id;
      r.uuid_high          = id ? id_hi : '0;
      r.uuid_low           = id ? id_lo : '0;
      return r;
   endfunction

   // ue(v) scan, MSB first
   task automatic scan_golomb(input logic [7:0] b);
      for (int i = 7; i >= 0; i--) begin
         case (eg_phase)
            GB_COUNT: begin
               if (b[i]) begin
                  eg_val = 32'd1;
                  if (eg_zeros == 0) begin
                     eg_phase = GB_DONE;
                  end else begin
                     eg_bits  = eg_zeros;
                     eg_phase = GB_READ;
                  end
               end else begin
                  eg_zeros++;
                  if (eg_zeros > GOLOMB_MAX_ZEROS) eg_phase = GB_FAIL;
               end
            end
            GB_READ: begin
               eg_val = {eg_val[30:0], b[i]};
               eg_bits--;
               if (eg_bits == 0) eg_phase = GB_DONE;
            end
            default: ;
         endcase
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      logic keep;
      logic emitted;
      keep    = 1'b1;
      emitted = 1'b0;

      // emulation prevention: 00 00 03 drops the 03
      if (zero_run >= 2 && b == EMU_BYTE) begin
         keep     = 1'b0;
         zero_run = '0;
      end else if (b == 8'h00) begin
         if (zero_run < 2) zero_run++;
      end else begin
         zero_run = '0;
      end

      if (keep && phase == PH_HEADER) begin
         if (hdr_left > 0) begin
            hdr_left--;
            keep = 1'b0;
         end else begin
            phase = PH_START;
         end
      end

      if (keep) begin
         if (phase == PH_START) begin
            if (b == TRAILING_BYTE) begin
               phase = PH_DONE;
            end else begin
               type_acc = '0;
               size_acc = '0;
               phase    = PH_TYPE;
            end
         end
         case (phase)
            PH_TYPE: begin
               type_acc = sat_sum(type_acc, b);
               if (b != RUN_BYTE) phase = PH_SIZE;
            end
            PH_SIZE: begin
               size_acc = sat_sum(size_acc, b);
               if (b != RUN_BYTE) begin
                  bytes_left = size_acc;
                  clear_payload();
                  if (size_acc == 0) begin
                     records_due = {records_due, make_record(1'b1)};
                     emitted     = 1'b1;
                     phase       = PH_START;
                  end else begin
                     phase = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (byte_pos < UUID_HIGH_BYTES) id_hi = {id_hi[55:0], b};
               else if (byte_pos < UUID_BYTES) id_lo = {id_lo[55:0], b};
               if (byte_pos < UUID_BYTES) byte_pos++;
               if (type_acc == TYPE_RECOVERY) scan_golomb(b);
               bytes_left--;
               if (bytes_left == 0) begin
                  records_due = {records_due, make_record(1'b1)};
                  emitted     = 1'b1;
                  phase       = PH_START;
               end
            end
            default: ;
         endcase
      end

      // unit end: cut-off payload gives a truncated record
      if (last) begin
         if (phase == PH_PAYLOAD && !emitted) records_due = {records_due, make_record(1'b0)};
         start_unit();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fault_tally++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         hdr_cfg = HEADER_RESET;
         start_unit();
         records_due.delete();
      end else begin
         // register write; reloads the skip count while still in the header
         if (csr_valid && csr_ready) begin
            hdr_cfg = csr_data;
            if (phase == PH_HEADER) hdr_left = csr_data;
         end

         if (rsp_valid && rsp_ready) begin
            if (records_due.size() == 0) begin
               fault_tally++;
               $error("unexpected record beat: type 0x%0h size 0x%0h",
                      rsp_data.sei_type, rsp_data.payload_size);
            end else begin
               want = records_due.pop_front();
               check_field("sei_type", want.sei_type, rsp_data.sei_type);
               check_field("payload_size", want.payload_size, rsp_data.payload_size);
               check_field("truncated", want.truncated, rsp_data.truncated);
               check_field("has_recovery_count", want.has_recovery_count,
                           rsp_data.has_recovery_count);
               check_field("recovery_count", want.recovery_count, rsp_data.recovery_count);
               check_field("has_uuid", want.has_uuid, rsp_data.has_uuid);
               check_field("uuid_high", want.uuid_high, rsp_data.uuid_high);
               check_field("uuid_low", want.uuid_low, rsp_data.uuid_low);
            end
         end

         if (req_valid && req_ready) take_byte(req_data.nal_byte, req_data.last_byte);
      end
      fault_count     <= fault_tally;
      records_pending <= records_due.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import smp_pkg::*;

   // a record passes the input and result registers after its last byte is accepted; drain margin covers it
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int PHASE_BYTES     = 32;
   // header byte count per phase, phase 0 in the low bits
   localparam logic [15:0] HDR_PLAN = {2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};

   logic clock;
   logic reset;

   smp_chan_if #(.data_type(req_type))    req_chan ();
   smp_chan_if #(.data_type(rsp_type))    rsp_chan ();
   smp_chan_if #(.data_type(logic [1:0])) csr_chan ();

   int fault_count;
   int records_pending;
   int cycle_count = 0;
   int items_sent  = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int hdr_now     = 1;
   int run_zeros   = 0;
   bit hold_off_go   = 1'b0;
   bit hold_off_done = 1'b0;

   logic [7:0] unit_bytes[$];

   sei_message_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   sei_record_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_data        (req_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_data        (rsp_chan.data),
      .csr_valid       (csr_chan.valid),
      .csr_ready       (csr_chan.ready),
      .csr_data        (csr_chan.data),
      .fault_count     (fault_count),
      .records_pending (records_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // record receiver: random stalls plus one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{nal_byte: b, last_byte: last};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_unit();
      for (int i = 0; i < unit_bytes.size(); i++)
         send_beat(unit_bytes[i], i == unit_bytes.size() - 1);
      items_sent += unit_bytes.size();
   endtask

   // wait for all records, then let the pipeline empty
   task automatic settle();
      @(posedge clock);
      while (records_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_header_bytes(input logic [1:0] v);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [7:0] zeroish_byte();
      return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(4))
         0: return 8'h00;
         1: return EMU_BYTE;
         2: return RUN_BYTE;
         3: return TRAILING_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // payload byte with encoder-style emulation insertion
   task automatic push_rbsp(input logic [7:0] b);
      if (run_zeros >= 2 && b <= EMU_BYTE) begin
         unit_bytes = {unit_bytes, EMU_BYTE};
         run_zeros  = 0;
      end
      unit_bytes = {unit_bytes, b};
      run_zeros  = (b == 8'h00) ? run_zeros + 1 : 0;
   endtask

   // 0xFF run plus final byte
   task automatic add_coded(input int v);
      while (v >= 255) begin
         push_rbsp(RUN_BYTE);
         v -= 255;
      end
      push_rbsp(v[7:0]);
   endtask

   task automatic add_message();
      int         kind;
      int         msg_type;
      int         msg_size;
      int         lead;
      logic [7:0] acc;
      logic [7:0] body[$];
      bit         code[$];
      acc  = '0;
      kind = $urandom_range(99);
      if (kind < 25) msg_type = TYPE_UUID;
      else if (kind < 60) msg_type = TYPE_RECOVERY;
      else if (kind < 70) msg_type = 255 + $urandom_range(0, 300);
      else msg_type = $urandom_range(0, 254);

      if (msg_type == TYPE_RECOVERY) begin
         // ue(v) code: deep prefixes now and then to hit the zero limit
         lead = ($urandom_range(4) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
         repeat (lead) code = {code, 1'b0};
         code = {code, 1'b1};
         repeat (lead) code = {code, 1'($urandom_range(1))};
         while (code.size() % 8 != 0) code = {code, 1'($urandom_range(1))};
         for (int i = 0; i < code.size(); i += 8) begin
            for (int j = 0; j < 8; j++) acc = {acc[6:0], code[i + j]};
            body = {body, acc};
         end
         msg_size = body.size() + $urandom_range(0, 2);
         // payload ends inside the code
         if ($urandom_range(4) == 0) msg_size = body.size() - 1;
      end else if (msg_type == TYPE_UUID) begin
         msg_size = ($urandom_range(2) != 0) ? $urandom_range(16, 24) : $urandom_range(0, 15);
      end else if ($urandom_range(29) == 0) begin
         msg_size = 255 + $urandom_range(0, 10);
      end else begin
         msg_size = $urandom_range(0, 12);
      end

      add_coded(msg_type);
      add_coded(msg_size);
      for (int i = 0; i < msg_size; i++)
         push_rbsp(i < body.size() ? body[i] : zeroish_byte());
   endtask

   task automatic build_unit();
      int cut;
      unit_bytes.delete();
      run_zeros = 0;
      // junk unit
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12)) unit_bytes = {unit_bytes, noise_byte()};
         return;
      end
      repeat (hdr_now) push_rbsp(8'($urandom_range(255)));
      repeat ($urandom_range(1, 4)) add_message();
      push_rbsp(TRAILING_BYTE);
      repeat ($urandom_range(0, 2)) unit_bytes = {unit_bytes, noise_byte()};
      // unit cut short somewhere
      if ($urandom_range(3) == 0) begin
         cut = $urandom_range(1, unit_bytes.size());
         while (unit_bytes.size() > cut) void'(unit_bytes.pop_back());
      end
   endtask

   initial begin
      int phase_end;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed units, one header byte after reset
      // recovery count 0, zero-size uuid type, trailing bits, junk after them
      unit_bytes = {8'h06, 8'h06, 8'h01, 8'h80, 8'h05, 8'h00, 8'h80, 8'hFF};
      send_unit();
      // final byte is an emulation byte inside a payload
      unit_bytes = {8'h06, 8'h01, 8'h04, 8'h00, 8'h00, 8'h03};
      send_unit();
      // multi-byte type and size, cut off early
      unit_bytes = {8'h06, 8'hFF, 8'hFF, 8'h02, 8'hFF, 8'h00, 8'h7F, 8'h80};
      send_unit();
      // type 0 size 0, unit ends at a message start
      unit_bytes = {8'h06, 8'h00, 8'h00};
      send_unit();

      // random phases: header count and idle pattern change per phase
      for (int p = 0; p < 8; p++) begin
         req_chan.valid <= 1'b0;
         settle();
         hdr_now = HDR_PLAN[p*2 +: 2];
         write_header_bytes(HDR_PLAN[p*2 +: 2]);
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 78; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
            default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
         endcase
         if (p == 4) hold_off_go <= 1'b1;
         phase_end = items_sent + PHASE_BYTES;
         while (items_sent < phase_end) begin
            build_unit();
            send_unit();
         end
      end

      req_chan.valid <= 1'b0;
      settle();
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/smp_pkg.sv
hw/rtl/smp_chan_if.sv
hw/rtl/smp_golomb_step.sv
hw/rtl/smp_parser_core.sv
hw/rtl/sei_message_parser.sv
tb/sv/sei_record_checker.sv
tb/sv/tb_top.sv
